/* rtl/evq_pkg.sv */
// Shared types and codes for the input event queue.
`default_nettype none
package evq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;
  localparam int unsigned CNT_W = 64;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_STAT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_POINTER = 2'd2,
    KIND_BUTTON  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SRC_NONE      = 2'd0,
    SRC_KEYBOARD  = 2'd1,
    SRC_MOUSE     = 2'd2,
    SRC_SYNTHETIC = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    STAT_PUSHED  = 3'd0,
    STAT_PUMPED  = 3'd1,
    STAT_POLLED  = 3'd2,
    STAT_DROPPED = 3'd3,
    STAT_PENDING = 3'd4,
    STAT_READY   = 3'd5
  } stat_sel_t;

  // one input word, split into fields
  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  kind;
    logic        from_device;
    logic [7:0]  key_char;
    logic        is_pressed;
    logic [31:0] pos_column;
    logic [31:0] pos_row;
    logic [31:0] move_column;
    logic [31:0] move_row;
    logic [7:0]  button_id;
    logic [2:0]  stat_select;
  } evt_in_t;

  // one queue slot
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  source;
    logic [7:0]  key_char;
    logic        pressed;
    logic [31:0] column;
    logic [31:0] row;
    logic [31:0] move_column;
    logic [31:0] move_row;
    logic [7:0]  button;
    logic [63:0] sequence_no;
  } slot_t;

  // result of one operation, apart from the popped slot
  typedef struct packed {
    logic             ok;
    logic             pop_hit;
    logic [CNT_W-1:0] stat_value;
  } res_t;

endpackage
`default_nettype wire

/* rtl/input_event_queue_with_sequence.sv */
// Top level of the input event queue: stream ports, result register.
//
// Input event queue with 64-bit sequence stamps. Each input word is one
// operation (initialize, push, pop, read statistic) and returns exactly one
// result word in the cycle after it is taken; a new word is taken every cycle
// while the result side keeps up. The result register and the registered
// read port of the slot memory hold that result; a stalled result
// holds while s_tready stays low. The queue powers up not ready: send an
// initialize first. The slots need no clearing pass after reset.
`default_nettype none
module input_event_queue_with_sequence
  import evq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata, low bit up: from_device[0], key_char[8:1], is_pressed[9],
  // pos_column[41:10], pos_row[73:42], move_column[105:74],
  // move_row[137:106], button_id[145:138], zero pad[151:146]
  input  wire logic [151:0] s_tdata,
  // s_tuser, low bit up: operation[1:0], kind[3:2], stat_select[6:4]
  input  wire logic [6:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, low bit up: out_char[7:0], out_pressed[8], out_column[40:9],
  // out_row[72:41], out_move_column[104:73], out_move_row[136:105],
  // out_button[144:137], out_sequence[208:145], stat_value[272:209],
  // zero pad[279:273]
  output logic [279:0]      m_tdata,
  // m_tuser, low bit up: ok[0], out_kind[2:1], out_source[4:3]
  output logic [4:0]        m_tuser
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  evt_in_t       evt;
  logic          acc;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  slot_t         wr_data, rd_data, slot_out;
  res_t          res, res_q;

  assign evt.operation   = s_tuser[1:0];
  assign evt.kind        = s_tuser[3:2];
  assign evt.stat_select = s_tuser[6:4];
  assign evt.from_device = s_tdata[0];
  assign evt.key_char    = s_tdata[8:1];
  assign evt.is_pressed  = s_tdata[9];
  assign evt.pos_column  = s_tdata[41:10];
  assign evt.pos_row     = s_tdata[73:42];
  assign evt.move_column = s_tdata[105:74];
  assign evt.move_row    = s_tdata[137:106];
  assign evt.button_id   = s_tdata[145:138];

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  evq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .evt     (evt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .res     (res)
  );

  evq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res;
    end
  end

  // event fields read zero unless a pop delivered a slot
  assign slot_out = res_q.pop_hit ? rd_data : '0;

  assign m_tuser = {slot_out.source, slot_out.kind, res_q.ok};
  assign m_tdata = {7'd0, res_q.stat_value, slot_out.sequence_no, slot_out.button,
                    slot_out.move_row, slot_out.move_column, slot_out.row,
                    slot_out.column, slot_out.pressed, slot_out.key_char};

endmodule
`default_nettype wire

/* rtl/evq_mem.sv */
// Slot storage: one write port, one registered read port.
`default_nettype none
module evq_mem
  import evq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_t              rd_data
);

  slot_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no pop is taken, so a stalled result stays put
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/evq_ctrl.sv */
// Queue control: pointers, fill count, sequence stamp and statistics.
`default_nettype none
module evq_ctrl
  import evq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          acc,
  input  wire evt_in_t       evt,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output slot_t              wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  output res_t               res
);

  logic [AW-1:0]    read_pointer, read_pointer_next;
  logic [AW-1:0]    write_pointer, write_pointer_next;
  logic [CW-1:0]    fill_count, fill_count_next;
  logic             ready_flag, ready_flag_next;
  logic [CNT_W-1:0] next_stamp, next_stamp_next;
  logic [CNT_W-1:0] pushed_total, pushed_total_next;
  logic [CNT_W-1:0] pumped_total, pumped_total_next;
  logic [CNT_W-1:0] polled_total, polled_total_next;
  logic [CNT_W-1:0] dropped_total, dropped_total_next;

  logic full, empty, bad_event, push_ok, pop_ok;
  logic [CNT_W-1:0] stat_sel_value;

  assign full  = (fill_count == CW'(QUEUE_DEPTH));
  assign empty = (fill_count == '0);
  assign bad_event = (evt.kind == KIND_NONE) ||
                     ((evt.kind == KIND_KEY) && (evt.key_char == 8'd0));
  assign push_ok = acc && (evt.operation == OP_PUSH) && ready_flag && !full && !bad_event;
  assign pop_ok  = acc && (evt.operation == OP_POP) && !empty;

  // slot contents: fields foreign to the kind are zeroed
  always_comb begin
    wr_data             = '0;
    wr_data.kind        = evt.kind;
    wr_data.sequence_no = next_stamp;
    if (!evt.from_device) begin
      wr_data.source = SRC_SYNTHETIC;
    end else if (evt.kind == KIND_KEY) begin
      wr_data.source = SRC_KEYBOARD;
    end else begin
      wr_data.source = SRC_MOUSE;
    end
    case (evt.kind)
      KIND_KEY: begin
        wr_data.key_char = evt.key_char;
        wr_data.pressed  = evt.is_pressed;
      end
      KIND_POINTER: begin
        wr_data.column      = evt.pos_column;
        wr_data.row         = evt.pos_row;
        wr_data.move_column = evt.move_column;
        wr_data.move_row    = evt.move_row;
      end
      KIND_BUTTON: begin
        wr_data.pressed = evt.is_pressed;
        wr_data.column  = evt.pos_column;
        wr_data.row     = evt.pos_row;
        wr_data.button  = evt.button_id;
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = push_ok;
  assign wr_addr = write_pointer;
  assign rd_en   = pop_ok;
  assign rd_addr = read_pointer;

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    ready_flag_next    = ready_flag;
    next_stamp_next    = next_stamp;
    pushed_total_next  = pushed_total;
    pumped_total_next  = pumped_total;
    polled_total_next  = polled_total;
    dropped_total_next = dropped_total;
    if (acc) begin
      case (evt.operation)
        OP_INIT: begin
          read_pointer_next  = '0;
          write_pointer_next = '0;
          fill_count_next    = '0;
          ready_flag_next    = 1'b1;
          next_stamp_next    = CNT_W'(1);
          pushed_total_next  = '0;
          pumped_total_next  = '0;
          polled_total_next  = '0;
          dropped_total_next = '0;
        end
        OP_PUSH: begin
          if (push_ok) begin
            write_pointer_next = (write_pointer == AW'(QUEUE_DEPTH - 1)) ?
                                 '0 : write_pointer + AW'(1);
            fill_count_next    = fill_count + CW'(1);
            next_stamp_next    = next_stamp + CNT_W'(1);
            pushed_total_next  = pushed_total + CNT_W'(1);
            if (evt.from_device) begin
              pumped_total_next = pumped_total + CNT_W'(1);
            end
          end else if (!(evt.from_device && (!ready_flag || full))) begin
            // device words refused for not ready or full are kept by the driver
            dropped_total_next = dropped_total + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (pop_ok) begin
            read_pointer_next = (read_pointer == AW'(QUEUE_DEPTH - 1)) ?
                                '0 : read_pointer + AW'(1);
            fill_count_next   = fill_count - CW'(1);
            polled_total_next = polled_total + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (evt.stat_select)
      STAT_PUSHED:  stat_sel_value = pushed_total;
      STAT_PUMPED:  stat_sel_value = pumped_total;
      STAT_POLLED:  stat_sel_value = polled_total;
      STAT_DROPPED: stat_sel_value = dropped_total;
      STAT_PENDING: stat_sel_value = CNT_W'(fill_count);
      STAT_READY:   stat_sel_value = CNT_W'(ready_flag);
      default:      stat_sel_value = '0;
    endcase
  end

  always_comb begin
    res.ok         = push_ok || pop_ok;
    res.pop_hit    = pop_ok;
    res.stat_value = (evt.operation == OP_STAT) ? stat_sel_value : CNT_W'(fill_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      ready_flag    <= 1'b0;
      next_stamp    <= CNT_W'(1);
      pushed_total  <= '0;
      pumped_total  <= '0;
      polled_total  <= '0;
      dropped_total <= '0;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
      ready_flag    <= ready_flag_next;
      next_stamp    <= next_stamp_next;
      pushed_total  <= pushed_total_next;
      pumped_total  <= pumped_total_next;
      polled_total  <= polled_total_next;
      dropped_total <= dropped_total_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full && ready_flag)
    else $error("slot written while full or not ready");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("slot read while empty");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    acc && (evt.operation == OP_INIT) |=>
      fill_count == '0 && next_stamp == CNT_W'(1) && ready_flag)
    else $error("initialize did not clear state");

  a_push_stamp: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> next_stamp == $past(next_stamp) + CNT_W'(1))
    else $error("sequence stamp did not advance on push");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the input event queue: scoreboard with FIFO model, stream drivers.
`timescale 1ns / 100ps
module testbench;
  import evq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    op_t         op;
    kind_t       kind;
    logic        dev;
    logic [7:0]  ch;
    logic        pr;
    logic [31:0] col;
    logic [31:0] row;
    logic [31:0] mc;
    logic [31:0] mr;
    logic [7:0]  btn;
    logic [2:0]  sel;
  } cmd_word_t;

  typedef struct {
    kind_t       kind;
    src_t        src;
    logic [7:0]  ch;
    logic        pr;
    logic [31:0] col;
    logic [31:0] row;
    logic [31:0] mc;
    logic [31:0] mr;
    logic [7:0]  btn;
    logic [63:0] seq;
  } queued_event_t;

  typedef struct {
    logic          ok;
    queued_event_t ev;
    logic [63:0]   stat;
  } reply_t;

  class event_queue_scoreboard;
    queued_event_t slots[DEPTH];
    int unsigned   rd_ptr, wr_ptr, fill;
    bit            ready;
    logic [63:0]   stamp, n_pushed, n_pumped, n_polled, n_dropped;
    reply_t        awaited[$];
    int            mismatches;

    function new();
      clear_counts();
      ready = 0;
      mismatches = 0;
    endfunction

    function void clear_counts();
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      stamp = 64'd1;
      n_pushed = '0;
      n_pumped = '0;
      n_polled = '0;
      n_dropped = '0;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // accepted input word: update the model and queue the reply it causes
    function void take_word(cmd_word_t w);
      reply_t        r;
      queued_event_t e;
      bit            full;
      e.kind = KIND_NONE;
      e.src = SRC_NONE;
      e.ch = '0;
      e.pr = 1'b0;
      e.col = '0;
      e.row = '0;
      e.mc = '0;
      e.mr = '0;
      e.btn = '0;
      e.seq = '0;
      r.ok = 1'b0;
      r.ev = e;
      full = (fill >= DEPTH);
      case (w.op)
        OP_INIT: begin
          clear_counts();
          ready = 1;
        end
        OP_PUSH: begin
          if (w.dev && (!ready || full)) begin
            // device keeps the event; nothing counted
          end else if (w.kind == KIND_NONE || (w.kind == KIND_KEY && w.ch == 8'd0) ||
                       !ready || full) begin
            n_dropped++;
          end else begin
            e.kind = w.kind;
            e.ch = w.ch;
            e.pr = w.pr;
            e.col = w.col;
            e.row = w.row;
            e.mc = w.mc;
            e.mr = w.mr;
            e.btn = w.btn;
            e.seq = stamp;
            if (w.kind == KIND_KEY) begin
              e.col = '0;
              e.row = '0;
              e.mc = '0;
              e.mr = '0;
              e.btn = '0;
            end else if (w.kind == KIND_POINTER) begin
              e.ch = '0;
              e.pr = 1'b0;
              e.btn = '0;
            end else begin
              e.ch = '0;
              e.mc = '0;
              e.mr = '0;
            end
            if (!w.dev) e.src = SRC_SYNTHETIC;
            else if (w.kind == KIND_KEY) e.src = SRC_KEYBOARD;
            else e.src = SRC_MOUSE;
            slots[wr_ptr] = e;
            stamp++;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
            n_pushed++;
            if (w.dev) n_pumped++;
            r.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (fill != 0) begin
            r.ev = slots[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
            n_polled++;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      if (w.op == OP_STAT) begin
        case (w.sel)
          STAT_PUSHED:  r.stat = n_pushed;
          STAT_PUMPED:  r.stat = n_pumped;
          STAT_POLLED:  r.stat = n_polled;
          STAT_DROPPED: r.stat = n_dropped;
          STAT_PENDING: r.stat = 64'(fill);
          STAT_READY:   r.stat = ready ? 64'd1 : 64'd0;
          default:      r.stat = '0;
        endcase
      end else begin
        r.stat = 64'(fill);
      end
      awaited.push_back(r);
    endfunction

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_word(logic [279:0] d, logic [4:0] u);
      reply_t r;
      if (awaited.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      r = awaited.pop_front();
      cmp("ok", 64'(u[0]), 64'(r.ok));
      cmp("kind", 64'(u[2:1]), 64'(r.ev.kind));
      cmp("source", 64'(u[4:3]), 64'(r.ev.src));
      cmp("char", 64'(d[7:0]), 64'(r.ev.ch));
      cmp("pressed", 64'(d[8]), 64'(r.ev.pr));
      cmp("column", 64'(d[40:9]), 64'(r.ev.col));
      cmp("row", 64'(d[72:41]), 64'(r.ev.row));
      cmp("move_column", 64'(d[104:73]), 64'(r.ev.mc));
      cmp("move_row", 64'(d[136:105]), 64'(r.ev.mr));
      cmp("button", 64'(d[144:137]), 64'(r.ev.btn));
      cmp("sequence", d[208:145], r.ev.seq);
      cmp("stat_value", d[272:209], r.stat);
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic [6:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [279:0] m_tdata;
  logic [4:0]   m_tuser;

  event_queue_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned accepted = 0;
  int unsigned cycles = 0;

  input_event_queue_with_sequence dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cmd_word_t word(op_t op, kind_t kind, logic dev, logic [7:0] ch,
                                     logic pr, logic [31:0] col, logic [31:0] row,
                                     logic [31:0] mc, logic [31:0] mr, logic [7:0] btn,
                                     logic [2:0] sel);
    cmd_word_t w;
    w.op = op;
    w.kind = kind;
    w.dev = dev;
    w.ch = ch;
    w.pr = pr;
    w.col = col;
    w.row = row;
    w.mc = mc;
    w.mr = mr;
    w.btn = btn;
    w.sel = sel;
    return w;
  endfunction

  // biased toward the edges of the 32-bit range
  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_word_t rand_word(op_t op, bit well_formed);
    cmd_word_t w;
    w = word(op, kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rand32(), rand32(),
             rand32(), rand32(), 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    if (well_formed) begin
      w.kind = kind_t'($urandom_range(1, 3));
      w.ch = 8'($urandom_range(1, 255));
    end else if ($urandom_range(0, 2) == 0) begin
      w.ch = 8'd0;
    end
    return w;
  endfunction

  // offer one word, wait for the handshake, then maybe leave a gap
  task automatic offer(cmd_word_t w);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, w.btn, w.mr, w.mc, w.row, w.col, w.pr, w.ch, w.dev};
    s_tuser <= {w.sel, w.kind, w.op};
    do @(posedge clk); while (!s_tready);
    sb.take_word(w);
    accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: own stall pattern, one long hold-off once the queue has traffic
  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    bit          held;
    held = 0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && accepted >= 120) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(4, 40);
        repeat (len) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= 1'b0;
            default: m_tready <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    cmd_word_t w;
    int        n_random;
    int        phase;
    int        len;
    int        r;
    bit        first;
    n_random = 0;
    first = 1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before initialize: not ready
    offer(word(OP_STAT, KIND_NONE, 1'b0, 8'h00, 1'b0, '0, '0, '0, '0, 8'h00, STAT_READY));
    offer(word(OP_PUSH, KIND_KEY, 1'b1, 8'h41, 1'b1, '0, '0, '0, '0, 8'h00, 3'd0));
    offer(word(OP_PUSH, KIND_POINTER, 1'b0, 8'h00, 1'b0, 32'd5, 32'd6, '0, '0, 8'h00, 3'd0));
    offer(word(OP_POP, KIND_NONE, 1'b0, 8'h00, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    offer(word(OP_INIT, KIND_NONE, 1'b0, 8'h00, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    // refusals once ready
    offer(word(OP_PUSH, KIND_KEY, 1'b1, 8'h00, 1'b1, '0, '0, '0, '0, 8'h00, 3'd0));
    offer(word(OP_PUSH, KIND_NONE, 1'b0, 8'h20, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    offer(word(OP_PUSH, KIND_NONE, 1'b1, 8'h20, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    // accepted pushes with foreign fields set to be cleared
    offer(word(OP_PUSH, KIND_KEY, 1'b1, 8'hff, 1'b1, '1, '1, '1, '1, 8'hff, 3'd7));
    offer(word(OP_PUSH, KIND_KEY, 1'b0, 8'h01, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    offer(word(OP_PUSH, KIND_POINTER, 1'b1, 8'hff, 1'b1, '1, '1, '1, '1, 8'hff, 3'd7));
    offer(word(OP_PUSH, KIND_POINTER, 1'b1, 8'h00, 1'b0, 32'h0, 32'hffff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 8'h00, 3'd0));
    offer(word(OP_PUSH, KIND_BUTTON, 1'b0, 8'hff, 1'b1, '1, '1, '1, '1, 8'hff, 3'd7));
    // five hits, then the empty pop
    repeat (6) offer(word(OP_POP, KIND_NONE, 1'b0, 8'h00, 1'b0, '0, '0, '0, '0, 8'h00, 3'd0));
    for (int s = 0; s < 8; s++)
      offer(word(OP_STAT, KIND_NONE, 1'b0, 8'h00, 1'b0, '0, '0, '0, '0, 8'h00, 3'(s)));

    while (n_random < RANDOM_WORDS) begin
      phase = first ? 0 : $urandom_range(0, 2);
      first = 0;
      len = (phase == 0) ? $urandom_range(60, 100) : $urandom_range(20, 70);
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (phase)
          0: begin  // fill toward full
            if (r < 80) w = rand_word(OP_PUSH, 1);
            else if (r < 88) w = rand_word(OP_POP, 0);
            else if (r < 96) w = rand_word(OP_PUSH, 0);
            else w = rand_word(OP_STAT, 0);
          end
          1: begin  // drain
            if (r < 75) w = rand_word(OP_POP, 0);
            else if (r < 90) w = rand_word(OP_PUSH, 1);
            else w = rand_word(OP_STAT, 0);
          end
          default: begin
            if (r < 3) w = rand_word(OP_INIT, 0);
            else if (r < 40) w = rand_word(OP_PUSH, 1);
            else if (r < 50) w = rand_word(OP_PUSH, 0);
            else if (r < 85) w = rand_word(OP_POP, 0);
            else w = rand_word(OP_STAT, 0);
          end
        endcase
        offer(w);
        n_random++;
        if (n_random == 250) begin
          // sender pause until every reply is back
          s_tvalid <= 1'b0;
          do @(posedge clk); while (sb.awaited.size() != 0);
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
